@@ design/transaction_slot_table_defines.svh @@
// Assertion helpers for the design file that carries concurrent checks.
`ifndef TRANSACTION_SLOT_TABLE_DEFINES_SVH
`define TRANSACTION_SLOT_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TST_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transaction_slot_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transaction_slot_table: next-cycle check failed");

`endif

@@ design/tst_pkg.sv @@
`default_nettype none

package tst_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_ACTIVE = 3'd1;
  localparam logic [2:0] OP_COMMIT = 3'd2;
  localparam logic [2:0] OP_ABORT  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_NO_AREA   = 3'd1;
  localparam logic [2:0] RS_BAD_INDEX = 3'd2;
  localparam logic [2:0] RS_FULL      = 3'd3;
  localparam logic [2:0] RS_BAD_STATE = 3'd4;
  localparam logic [2:0] RS_BAD_STAMP = 3'd5;
  localparam logic [2:0] RS_SLOT_FREE = 3'd6;

  localparam logic [1:0] SLOT_FREE      = 2'd0;
  localparam logic [1:0] SLOT_ACTIVE    = 2'd1;
  localparam logic [1:0] SLOT_COMMITTED = 2'd2;
  localparam logic [1:0] SLOT_ABORTED   = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  slot_index;
    logic [31:0] owner_id;
    logic [63:0] write_stamp;
    logic [63:0] commit_stamp;
    logic [63:0] undo_head;
  } tst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [1:0]  state_out;
    logic [31:0] owner_out;
    logic [15:0] reuse_count;
    logic [63:0] commit_out;
    logic [63:0] write_out;
    logic [63:0] undo_out;
    logic        commit_cached;
  } tst_out_t;

  // Wide per-slot contents kept in the payload RAM.
  typedef struct packed {
    logic [15:0] reuse;
    logic [63:0] commit;
    logic [63:0] write;
    logic [63:0] undo;
  } tst_slot_t;

  localparam int SLOT_DATA_W = $bits(tst_slot_t);

endpackage

`default_nettype wire

@@ design/transaction_slot_table.sv @@
// Transaction slot table: one operation per beat, one result beat per operation.
// The request is registered at acceptance and the execute state registers the result.
// New operations stall until the current one ends its payload RAM read-modify-write.
// A stalled result holds the block in its execute cycle until the result register frees up.
// Reset (rst, synchronous, active high) frees every slot at once through per-slot valid
// bits and the state flops; there is no clearing pass, and area_present returns to 1.
`default_nettype none

`include "transaction_slot_table_defines.svh"

module transaction_slot_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tst_pkg::tst_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tst_pkg::tst_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata
);

  import tst_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  fsm_t fsm;

  // The slot state and owner words live in flops because allocate looks at all of
  // them at once. The wide payload (reuse counter, stamps, undo head) lives in a RAM
  // with a registered read; a valid bit per slot makes a never-written
  // entry read as its reset value of zero.
  logic [1:0]  tag_state [SLOT_COUNT];
  logic [31:0] tag_owner [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] data_valid;

  logic area_present;

  // Request captured at acceptance.
  tst_in_t           req;
  logic [SLOT_W-1:0] req_slot;
  logic              req_alloc_hit;
  logic              req_bad_index;

  logic in_fire;
  logic exec_fire;

  logic [SLOT_W-1:0] alloc_slot;
  logic              alloc_hit;
  logic [SLOT_W-1:0] sel_slot;

  tst_slot_t ram_rd_data;
  tst_slot_t ram_wr_data;
  logic      ram_we;

  tst_out_t  result;

  assign in_stall  = (fsm != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  // The execute cycle completes once the result register is empty or being drained.
  assign exec_fire = (fsm == S_EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      area_present <= 1'b1;
    end else if (cfg_we) begin
      area_present <= cfg_wdata;
    end
  end

  // Allocate search: an active slot of the same owner wins, then the first free slot,
  // then the first committed or aborted slot. The loops run from the top down so that
  // the lowest matching slot is the one that remains.
  always_comb begin
    logic [SLOT_W-1:0] own_slot;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] reuse_slot;
    logic              own_hit;
    logic              free_hit;
    logic              reuse_hit;
    own_slot   = '0;
    free_slot  = '0;
    reuse_slot = '0;
    own_hit    = 1'b0;
    free_hit   = 1'b0;
    reuse_hit  = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (tag_state[i] == SLOT_ACTIVE && tag_owner[i] == in_data.owner_id) begin
        own_slot = SLOT_W'(i);
        own_hit  = 1'b1;
      end
      if (tag_state[i] == SLOT_FREE) begin
        free_slot = SLOT_W'(i);
        free_hit  = 1'b1;
      end
      if (tag_state[i] != SLOT_ACTIVE) begin
        reuse_slot = SLOT_W'(i);
        reuse_hit  = 1'b1;
      end
    end
    alloc_hit = own_hit || free_hit || reuse_hit;
    if (own_hit) begin
      alloc_slot = own_slot;
    end else if (free_hit) begin
      alloc_slot = free_slot;
    end else begin
      alloc_slot = reuse_slot;
    end
  end

  assign sel_slot = (in_data.op == OP_ALLOC) ? alloc_slot : in_data.slot_index[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req           <= in_data;
      req_slot      <= sel_slot;
      req_alloc_hit <= alloc_hit;
      req_bad_index <= (in_data.slot_index >= 8'(SLOT_COUNT));
    end
  end

  tst_ram #(
    .WIDTH (SLOT_DATA_W),
    .DEPTH (SLOT_COUNT)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (req_slot),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (sel_slot),
    .rd_data (ram_rd_data)
  );

  // Execute: check preconditions in order, modify the slot and build the result beat.
  // A failing operation leaves the table untouched and reports only its status.
  logic [1:0]  new_state;
  logic [31:0] new_owner;
  tst_slot_t   new_data;
  logic        tag_we;

  always_comb begin
    logic [1:0]  cur_state;
    logic [31:0] cur_owner;
    tst_slot_t   cur_data;
    logic [2:0]  status;
    logic        writes;
    cur_state = tag_state[req_slot];
    cur_owner = tag_owner[req_slot];
    cur_data  = data_valid[req_slot] ? ram_rd_data : '0;
    new_state = cur_state;
    new_owner = cur_owner;
    new_data  = cur_data;
    writes    = 1'b0;
    status    = RS_OK;

    if (!area_present) begin
      status = RS_NO_AREA;
    end else if (req.op > OP_READ) begin
      status = RS_BAD_STATE;
    end else if (req.op == OP_ALLOC) begin
      if (!req_alloc_hit) begin
        status = RS_FULL;
      end
    end else if (req_bad_index) begin
      status = RS_BAD_INDEX;
    end else begin
      case (req.op)
        OP_ACTIVE: begin
          // Rebinding a slot counts as a reuse unless it was free or already ours.
          if (cur_state != SLOT_FREE &&
              !(cur_state == SLOT_ACTIVE && cur_owner == req.owner_id)) begin
            new_data.reuse = cur_data.reuse + 16'd1;
          end
          new_state      = SLOT_ACTIVE;
          new_owner      = req.owner_id;
          new_data.commit = '0;
          new_data.write = req.write_stamp;
          new_data.undo  = req.undo_head;
          writes         = 1'b1;
        end
        OP_COMMIT: begin
          if (req.commit_stamp == '0) begin
            status = RS_BAD_STAMP;
          end else if (cur_state != SLOT_ACTIVE) begin
            status = RS_BAD_STATE;
          end else begin
            new_state       = SLOT_COMMITTED;
            new_data.commit = req.commit_stamp;
            writes          = 1'b1;
          end
        end
        OP_ABORT: begin
          if (cur_state != SLOT_ACTIVE) begin
            status = RS_BAD_STATE;
          end else begin
            new_state       = SLOT_ABORTED;
            new_data.commit = '0;
            writes          = 1'b1;
          end
        end
        default: begin
          if (cur_state == SLOT_FREE) begin
            status = RS_SLOT_FREE;
          end
        end
      endcase
    end

    result = '0;
    if (status != RS_OK) begin
      result.status = status;
    end else begin
      result.status        = RS_OK;
      result.slot_out      = 3'(req_slot);
      result.state_out     = new_state;
      result.owner_out     = new_owner;
      result.reuse_count   = new_data.reuse;
      result.commit_out    = new_data.commit;
      result.write_out     = new_data.write;
      result.undo_out      = new_data.undo;
      result.commit_cached = (new_state == SLOT_COMMITTED) && (new_data.commit != '0);
    end

    tag_we = exec_fire && (status == RS_OK) && writes;
  end

  assign ram_we      = tag_we;
  assign ram_wr_data = new_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag_state[i] <= SLOT_FREE;
        tag_owner[i] <= '0;
      end
      data_valid <= '0;
    end else if (tag_we) begin
      tag_state[req_slot]  <= new_state;
      tag_owner[req_slot]  <= new_owner;
      data_valid[req_slot] <= 1'b1;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (fsm)
        S_IDLE: begin
          if (in_fire) begin
            fsm <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            fsm <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
      if (exec_fire) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted beat always moves the sequencer into its execute cycle.
  `TST_ASSERT_NEXT(a_accept_to_exec, clk, rst, in_fire, fsm == S_EXEC)
  // Table updates happen only while an operation completes.
  `TST_ASSERT_SAME(a_write_in_exec, clk, rst, tag_we, exec_fire)
  // A completed operation always produces a result beat.
  `TST_ASSERT_NEXT(a_exec_gives_result, clk, rst, exec_fire, out_valid)
  // A failing operation carries nothing but its status.
  `TST_ASSERT_SAME(a_error_fields_zero, clk, rst,
    out_valid && out_data.status != RS_OK,
    out_data.owner_out == '0 && out_data.state_out == SLOT_FREE && !out_data.commit_cached)

endmodule

`default_nettype wire

@@ design/tst_ram.sv @@
`default_nettype none

module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
